FILE: rtl/bbe_pkg.sv
package bbe_pkg;

    localparam int MAX_DEGREE = 31;
    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int IDX_W      = 5;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int SUM_W      = VAL_W + 1;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;
    localparam int DEPTH      = MAX_DEGREE + 1;

    localparam logic [VAL_W-1:0]  FIX_ONE     = VAL_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] FIX_HALF    = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [IDX_W-1:0]  DEGREE_INIT = IDX_W'(MAX_DEGREE);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_INIT,
        ST_PASS,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_LOAD
    } state_t;

endpackage

FILE: rtl/bernstein_basis_eval.sv
// Bernstein basis evaluator.
// A request on the s_ channel carries a position t in [0,1] with 16 fraction bits;
// positions above 1.0 are treated as 1.0. For the configured degree n the block
// returns n+1 results on the m_ channel, basis values B(0,n)..B(n,n) in index
// order, with m_tlast on the final one. The degree is written on the cfg_
// channel, which is always ready, and should only change while the block is idle.
// One position at a time is processed: s_tready is high only when idle.
// A setup step writes B(0,0) = 1.0, then raising the degree from 0 to n takes n passes
// of one shared pair of 17x17 multipliers, pass i sweeping entries i down to 0 and
// followed by a pipeline drain, and each result is then read from the basis memory.
// The last result can be taken at the same edge at which the next position is
// accepted: the output register lets the next position be accepted while the last
// result still waits. If the receiver stalls, the current result is held and the
// sequencer waits. Reset sets the degree to 31 and leaves the block idle.
module bernstein_basis_eval
    import bbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [16:0] position, rest zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [16:0] basis_value, [21:17] basis_index
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_data
);

    logic [VAL_W-1:0] basis_mem [DEPTH];

    state_t state_reg, state_next;
    logic [IDX_W-1:0] deg_reg, deg_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [VAL_W-1:0] t_reg, t_next;
    logic [VAL_W-1:0] omt_reg, omt_next;
    logic [IDX_W-1:0] outer_reg, outer_next;
    logic [IDX_W-1:0] inner_reg, inner_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic             drain_reg, drain_next;

    logic             a_valid_reg, a_valid_next;
    logic [IDX_W-1:0] a_addr_reg, a_addr_next;
    logic             a_top_reg, a_top_next;
    logic             a_bot_reg, a_bot_next;
    logic             b_valid_reg, b_valid_next;
    logic [IDX_W-1:0] b_addr_reg, b_addr_next;

    logic [PROD_W-1:0] prod_t_reg, prod_t_next;
    logic [PROD_W-1:0] prod_o_reg, prod_o_next;
    logic [VAL_W-1:0]  upper_reg, upper_next;
    logic [VAL_W-1:0]  rd_data_reg;

    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] m_value_reg, m_value_next;
    logic [IDX_W-1:0] m_index_reg, m_index_next;
    logic             m_last_reg, m_last_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             init_wr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;

    logic [VAL_W-1:0]  pos;
    logic [VAL_W-1:0]  t_sat;
    logic [VAL_W-1:0]  op_t;
    logic [VAL_W-1:0]  op_o;
    logic [PROD_W-1:0] rnd_t_full;
    logic [PROD_W-1:0] rnd_o_full;
    logic [SUM_W-1:0]  sum;
    logic [VAL_W-1:0]  sat_sum;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W - VAL_W - IDX_W){1'b0}}, m_index_reg, m_value_reg};
    assign m_tlast   = m_last_reg;

    assign pos   = s_tdata[VAL_W-1:0];
    assign t_sat = (pos > FIX_ONE) ? FIX_ONE : pos;

    // The bottom entry has no lower neighbour and the new top entry no old value.
    assign op_t = a_bot_reg ? '0 : rd_data_reg;
    assign op_o = a_top_reg ? '0 : upper_reg;

    assign rnd_t_full = prod_t_reg + FIX_HALF;
    assign rnd_o_full = prod_o_reg + FIX_HALF;
    assign sum        = {1'b0, rnd_t_full[FRAC_BITS +: VAL_W]}
                      + {1'b0, rnd_o_full[FRAC_BITS +: VAL_W]};
    assign sat_sum    = (sum > {1'b0, FIX_ONE}) ? FIX_ONE : sum[VAL_W-1:0];

    assign wr_en   = init_wr || b_valid_reg;
    assign wr_addr = init_wr ? '0 : b_addr_reg;
    assign wr_data = init_wr ? FIX_ONE : sat_sum;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            basis_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= basis_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        deg_next     = deg_reg;
        n_next       = n_reg;
        t_next       = t_reg;
        omt_next     = omt_reg;
        outer_next   = outer_reg;
        inner_next   = inner_reg;
        out_idx_next = out_idx_reg;
        drain_next   = drain_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        init_wr      = 1'b0;

        a_valid_next = 1'b0;
        a_addr_next  = a_addr_reg;
        a_top_next   = a_top_reg;
        a_bot_next   = a_bot_reg;
        b_valid_next = a_valid_reg;
        b_addr_next  = a_addr_reg;
        prod_t_next  = prod_t_reg;
        prod_o_next  = prod_o_reg;
        upper_next   = upper_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_value_next = m_value_reg;
        m_index_next = m_index_reg;
        m_last_next  = m_last_reg;

        if (cfg_valid)
        begin
            deg_next = cfg_data;
        end

        if (a_valid_reg)
        begin
            prod_t_next = PROD_W'(t_reg) * PROD_W'(op_t);
            prod_o_next = PROD_W'(omt_reg) * PROD_W'(op_o);
            upper_next  = rd_data_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    t_next     = t_sat;
                    omt_next   = FIX_ONE - t_sat;
                    n_next     = deg_reg;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                init_wr = 1'b1;
                if (n_reg == '0)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT_RD;
                end
                else
                begin
                    outer_next = IDX_W'(1);
                    inner_next = IDX_W'(1);
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                rd_en        = (inner_reg != '0);
                rd_addr      = inner_reg - IDX_W'(1);
                a_valid_next = 1'b1;
                a_addr_next  = inner_reg;
                a_top_next   = (inner_reg == outer_reg);
                a_bot_next   = (inner_reg == '0);
                if (inner_reg == '0)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    inner_next = inner_reg - IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!drain_reg)
                begin
                    drain_next = 1'b1;
                end
                else if (outer_reg == n_reg)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT_RD;
                end
                else
                begin
                    outer_next = outer_reg + IDX_W'(1);
                    inner_next = outer_reg + IDX_W'(1);
                    state_next = ST_PASS;
                end
            end
            ST_OUT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = out_idx_reg;
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_value_next = rd_data_reg;
                    m_index_next = out_idx_reg;
                    m_last_next  = (out_idx_reg == n_reg);
                    if (out_idx_reg == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + IDX_W'(1);
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            deg_reg     <= DEGREE_INIT;
            outer_reg   <= '0;
            inner_reg   <= '0;
            out_idx_reg <= '0;
            drain_reg   <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            deg_reg     <= deg_next;
            outer_reg   <= outer_next;
            inner_reg   <= inner_next;
            out_idx_reg <= out_idx_next;
            drain_reg   <= drain_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        t_reg       <= t_next;
        omt_reg     <= omt_next;
        a_addr_reg  <= a_addr_next;
        a_top_reg   <= a_top_next;
        a_bot_reg   <= a_bot_next;
        b_addr_reg  <= b_addr_next;
        prod_t_reg  <= prod_t_next;
        prod_o_reg  <= prod_o_next;
        upper_reg   <= upper_next;
        m_value_reg <= m_value_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

`ifndef NO_ASSERTIONS
    // The multiply pipeline must be empty whenever a new position can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(a_valid_reg || b_valid_reg))
        else $error("multiply pipeline busy while idle");

    // A recurrence write never lands above the entry of the current pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_addr_reg <= outer_reg))
        else $error("basis write beyond current degree");

    // An accepted position always starts with the setup cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_INIT))
        else $error("accepted position did not start setup");
`endif

endmodule

FILE: dv/bernstein_basis_eval_tb.sv
`timescale 1ns / 100ps

module bernstein_basis_eval_tb;
    import bbe_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int HOLD_CYCLES  = 1500;

    typedef struct packed
    {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             last;
    } basis_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_data = '0;

    logic [VAL_W-1:0] positions_pending[$];
    basis_beat_t      basis_due[$];
    logic [IDX_W-1:0] degree_now = DEGREE_INIT;
    bit               idle_on = 1'b1;
    bit               hold_req = 1'b0;
    bit               hold_done = 1'b0;
    int               hold_left = 0;
    int               send_gap = 0;
    int               stall_left = 0;
    int               errors = 0;
    int               cycles = 0;
    logic             offer;
    logic             take;

    bernstein_basis_eval DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint unsigned round_mul(input longint unsigned a,
                                                  input longint unsigned b);
        return (a * b + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    task automatic predict_basis(input logic [VAL_W-1:0] pos);
        longint unsigned t;
        longint unsigned omt;
        longint unsigned one;
        longint unsigned sum;
        longint unsigned b[0:MAX_DEGREE];
        int              n;
        basis_beat_t     beat;
        one = longint'(FIX_ONE);
        t = (pos > FIX_ONE) ? one : longint'(pos);
        omt = one - t;
        n = degree_now;
        if (n == 0)
            b[0] = one;
        else
        begin
            b[0] = omt;
            b[1] = t;
            for (int i = 2; i <= n; i++)
            begin
                b[i] = round_mul(t, b[i-1]);
                for (int j = i - 1; j >= 1; j--)
                begin
                    sum = round_mul(t, b[j-1]) + round_mul(omt, b[j]);
                    b[j] = (sum > one) ? one : sum;
                end
                b[0] = round_mul(omt, b[0]);
            end
        end
        for (int j = 0; j <= n; j++)
        begin
            beat.value = VAL_W'(b[j]);
            beat.index = IDX_W'(j);
            beat.last  = (j == n);
            basis_due.push_back(beat);
        end
    endtask

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_basis();
        basis_beat_t want;
        if (basis_due.size() == 0)
        begin
            report($sformatf("unexpected basis value %0d index %0d",
                             m_tdata[VAL_W-1:0], m_tdata[VAL_W+IDX_W-1:VAL_W]));
            return;
        end
        want = basis_due.pop_front();
        if (m_tdata[VAL_W-1:0] !== want.value)
            report($sformatf("basis_value index %0d: expected %0d, got %0d",
                             want.index, want.value, m_tdata[VAL_W-1:0]));
        if (m_tdata[VAL_W+IDX_W-1:VAL_W] !== want.index)
            report($sformatf("basis_index: expected %0d, got %0d",
                             want.index, m_tdata[VAL_W+IDX_W-1:VAL_W]));
        if (m_tlast !== want.last)
            report($sformatf("last_value index %0d: expected %0d, got %0d",
                             want.index, want.last, m_tlast));
    endtask

    // Position requests are offered from the pending queue and predicted on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap = 0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_basis(s_tdata[VAL_W-1:0]);
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (positions_pending.size() != 0)
                begin
                    s_tdata <= S_DATA_W'(positions_pending.pop_front());
                    offer = 1'b1;
                    send_gap = idle_on ? gap_len() : 0;
                end
            end
            s_tvalid <= offer;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_basis();
            if (hold_left != 0)
                take = 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                take = 1'b0;
            end
            else
            begin
                take = 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    stall_left = gap_len();
            end
            m_tready <= take;
        end
    end

    // A long receiver hold-off, so that the block backs up and refuses requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (positions_pending.size() != 0 || s_tvalid || basis_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_degree(input logic [IDX_W-1:0] d);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        degree_now = d;
        @(negedge clk);
    endtask

    task automatic queue_positions(input logic [VAL_W-1:0] list[]);
        foreach (list[k])
            positions_pending.push_back(list[k]);
    endtask

    initial
    begin
        int r;
        logic [IDX_W-1:0] d;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The reset degree is used before any write.
        queue_positions('{17'd0, 17'd65536, 17'h1FFFF, 17'd32768});
        write_degree(5'd0);
        queue_positions('{17'd0, 17'd65536, 17'd70000, 17'd1});
        write_degree(5'd1);
        queue_positions('{17'd0, 17'd1, 17'd65535, 17'd65536, 17'd100000});
        write_degree(5'd2);
        queue_positions('{17'd32768, 17'd1, 17'd65535, 17'h1FFFF});
        write_degree(5'd31);
        queue_positions('{17'd1, 17'd65535, 17'd43690, 17'd21845});

        for (int ph = 0; ph < 13; ph++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                d = 5'd31;
            else if (r == 1)
                d = IDX_W'($urandom_range(9, 30));
            else
                d = IDX_W'($urandom_range(0, 8));
            write_degree(d);
            idle_on = (ph != 3);
            if (ph == 1)
                hold_req = 1'b1;
            for (int k = 0; k < 20; k++)
            begin
                r = $urandom_range(0, 19);
                case (r)
                    0: positions_pending.push_back(VAL_W'(0));
                    1: positions_pending.push_back(FIX_ONE);
                    2: positions_pending.push_back(VAL_W'($urandom_range(65537, 131071)));
                    3: positions_pending.push_back(VAL_W'($urandom_range(0, 15)));
                    4: positions_pending.push_back(VAL_W'($urandom_range(65520, 65535)));
                    default: positions_pending.push_back(VAL_W'($urandom_range(0, 65536)));
                endcase
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bbe_pkg.sv
rtl/bernstein_basis_eval.sv
dv/bernstein_basis_eval_tb.sv
